### hw/rtl/qmi_pkg.sv
// ----------------------------------------------------------------------------
// qmi_pkg
// Shared types and codes for the queue with middle insertion.
// ----------------------------------------------------------------------------
package qmi_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 1024;
	localparam int unsigned DATA_W          = 32;
	localparam int unsigned REQ_W           = 2;
	localparam int unsigned STATUS_W        = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_POP         = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PUSH_MIDDLE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_POP_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

	// operation broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_INSERT
	} cell_op_t;

endpackage

### hw/rtl/qmi_cell.sv
// ----------------------------------------------------------------------------
// qmi_cell
// One queue slot. Shifts toward the front on a pop, and on an insert takes
// the new value, its left neighbor's value, or holds, by its place vs pos.
// ----------------------------------------------------------------------------
module qmi_cell #(
	parameter int unsigned CNT_W = 11,
	parameter int unsigned INDEX = 0
) (
	input  logic                                 clk,
	input  qmi_pkg::cell_op_t                    op,
	input  logic [CNT_W-1:0]                     pos,
	input  logic signed [qmi_pkg::DATA_W-1:0]    ins_value,
	input  logic signed [qmi_pkg::DATA_W-1:0]    left_data,
	input  logic signed [qmi_pkg::DATA_W-1:0]    right_data,
	output logic signed [qmi_pkg::DATA_W-1:0]    data_q
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

	logic signed [qmi_pkg::DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (op)
			qmi_pkg::CELL_SHIFT: begin
				data_d = right_data;
			end
			qmi_pkg::CELL_INSERT: begin
				if (MY_IDX == pos) begin
					data_d = ins_value;
				end else if (MY_IDX > pos) begin
					data_d = left_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

### hw/rtl/queue_with_middle_insert_core.sv
// ----------------------------------------------------------------------------
// queue_with_middle_insert_core
// Bounded ordered queue with pop-front, push-back and push-middle requests.
//
// For each request, busy is high for the cycle after
// start is taken, while the whole row of cells moves in one step (pop shifts
// every cell toward the front, an insert opens a gap at the target slot).
// A result (pop data, pop on empty, push on full) appears on popped_value
// and status with done high for exactly one cycle, the cycle after busy; it
// is not held, so the receiver must take it then. Successful pushes and
// unknown request codes give no result. Entries are never cleared; only
// slots below the current count are ever read out.
// ----------------------------------------------------------------------------
module queue_with_middle_insert_core #(
	parameter int unsigned QUEUE_DEPTH = qmi_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [qmi_pkg::REQ_W-1:0]             req_type,
	input  logic signed [qmi_pkg::DATA_W-1:0]     value,
	output logic                                  done,
	output logic signed [qmi_pkg::DATA_W-1:0]     popped_value,
	output logic [qmi_pkg::STATUS_W-1:0]          status
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	logic [CNT_W-1:0]                   count_q;
	logic                               valid_s1;
	qmi_pkg::cell_op_t                  op_s1;
	logic [CNT_W-1:0]                   pos_s1;
	logic signed [qmi_pkg::DATA_W-1:0]  value_s1;
	logic                               emit_s1;
	logic [qmi_pkg::STATUS_W-1:0]       status_s1;

	logic                               accept;
	qmi_pkg::cell_op_t                  op_d;
	logic [CNT_W-1:0]                   pos_d;
	logic [CNT_W-1:0]                   count_d;
	logic                               emit_d;
	logic [qmi_pkg::STATUS_W-1:0]       status_d;
	qmi_pkg::cell_op_t                  cell_op;

	logic signed [qmi_pkg::DATA_W-1:0]  cell_data [QUEUE_DEPTH];

	logic                               done_q;
	logic signed [qmi_pkg::DATA_W-1:0]  popped_value_q;
	logic [qmi_pkg::STATUS_W-1:0]       status_q;

	assign busy   = valid_s1;
	assign accept = start & ~valid_s1;

	// decode the request against the current count
	always_comb begin
		op_d     = qmi_pkg::CELL_HOLD;
		pos_d    = count_q;
		count_d  = count_q;
		emit_d   = 1'b0;
		status_d = qmi_pkg::ST_POP_OK;
		case (req_type)
			qmi_pkg::REQ_POP: begin
				emit_d = 1'b1;
				if (count_q == '0) begin
					status_d = qmi_pkg::ST_POP_EMPTY;
				end else begin
					op_d    = qmi_pkg::CELL_SHIFT;
					count_d = count_q - ONE_C;
				end
			end
			qmi_pkg::REQ_PUSH_BACK, qmi_pkg::REQ_PUSH_MIDDLE: begin
				if (count_q == DEPTH_C) begin
					emit_d   = 1'b1;
					status_d = qmi_pkg::ST_PUSH_FULL;
				end else begin
					op_d    = qmi_pkg::CELL_INSERT;
					count_d = count_q + ONE_C;
					// count < depth here, so count+1 fits
					if (req_type == qmi_pkg::REQ_PUSH_MIDDLE && count_q != '0) begin
						pos_d = (count_q + ONE_C) >> 1;
					end
				end
			end
			default: begin
				op_d = qmi_pkg::CELL_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
			op_s1    <= qmi_pkg::CELL_HOLD;
			emit_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				count_q <= count_d;
				op_s1   <= op_d;
				emit_s1 <= emit_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1    <= pos_d;
			value_s1  <= value;
			status_s1 <= status_d;
		end
	end

	assign cell_op = valid_s1 ? op_s1 : qmi_pkg::CELL_HOLD;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic signed [qmi_pkg::DATA_W-1:0] left_data;
		logic signed [qmi_pkg::DATA_W-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_left
			assign left_data = cell_data[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_right
			assign right_data = cell_data[i+1];
		end

		qmi_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.op         (cell_op),
			.pos        (pos_s1),
			.ins_value  (value_s1),
			.left_data  (left_data),
			.right_data (right_data),
			.data_q     (cell_data[i])
		);
	end

	// front cell still holds the old head during the shift cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1 & emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q       <= status_s1;
			popped_value_q <= (op_s1 == qmi_pkg::CELL_SHIFT) ? cell_data[0] : '0;
		end
	end

	assign done         = done_q;
	assign popped_value = popped_value_q;
	assign status       = status_q;

endmodule

### verif/queue_with_middle_insert_checker.sv
// ----------------------------------------------------------------------------
// queue_with_middle_insert_checker
// Watches the request and result channels of the middle-insert queue, keeps a
// shadow copy of the queue contents, predicts each result and compares it.
// ----------------------------------------------------------------------------
module queue_with_middle_insert_checker #(
	parameter int QUEUE_DEPTH = qmi_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [qmi_pkg::REQ_W-1:0]         req_type,
	input  logic signed [qmi_pkg::DATA_W-1:0] value,
	input  logic                              done,
	input  logic signed [qmi_pkg::DATA_W-1:0] popped_value,
	input  logic [qmi_pkg::STATUS_W-1:0]      status,
	output int                                mismatches,
	output int                                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [qmi_pkg::DATA_W-1:0] data;
		logic [qmi_pkg::STATUS_W-1:0]      code;
	} reply_t;

	logic signed [qmi_pkg::DATA_W-1:0] shadow_entries [QUEUE_DEPTH];
	int                                shadow_count;
	reply_t                            due_replies [$];

	// Update the shadow queue for one accepted request and queue its reply, if any.
	task automatic apply_request(input logic [qmi_pkg::REQ_W-1:0] kind,
			input logic signed [qmi_pkg::DATA_W-1:0] data);
		int slot;
		if (kind == qmi_pkg::REQ_POP) begin
			if (shadow_count == 0) begin
				due_replies.push_back(reply_t'{data: '0, code: qmi_pkg::ST_POP_EMPTY});
			end else begin
				due_replies.push_back(reply_t'{data: shadow_entries[0],
					code: qmi_pkg::ST_POP_OK});
				for (int i = 0; i < shadow_count - 1; i++)
					shadow_entries[i] = shadow_entries[i + 1];
				shadow_count--;
			end
		end else if (kind == qmi_pkg::REQ_PUSH_BACK || kind == qmi_pkg::REQ_PUSH_MIDDLE) begin
			if (shadow_count >= QUEUE_DEPTH) begin
				due_replies.push_back(reply_t'{data: '0, code: qmi_pkg::ST_PUSH_FULL});
			end else begin
				// a middle insert into an empty queue lands at slot 0 like a push-back
				if (kind == qmi_pkg::REQ_PUSH_MIDDLE && shadow_count != 0)
					slot = (shadow_count + 1) / 2;
				else
					slot = shadow_count;
				for (int i = shadow_count; i > slot; i--)
					shadow_entries[i] = shadow_entries[i - 1];
				shadow_entries[slot] = data;
				shadow_count++;
			end
		end
	endtask

	task automatic report(input string msg);
		$error("%s", msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t exp;
		if (!arst_n) begin
			shadow_count = 0;
			due_replies.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// compare before predicting: a result never belongs to the
			// transaction taken at the same edge
			if (done) begin
				if (due_replies.size() == 0) begin
					report($sformatf("unexpected result: popped_value %0d status %0d",
						popped_value, status));
				end else begin
					exp = due_replies.pop_front();
					if (popped_value !== exp.data)
						report($sformatf("popped_value expected %0d actual %0d",
							exp.data, popped_value));
					if (status !== exp.code)
						report($sformatf("status expected %0d actual %0d",
							exp.code, status));
				end
			end
			if (start && !busy)
				apply_request(req_type, value);
			outstanding <= due_replies.size();
		end
	end

endmodule

### verif/queue_with_middle_insert_core_tb.sv
// ----------------------------------------------------------------------------
// queue_with_middle_insert_core_tb
// Drives pop, push-back and push-middle requests in random bursts, including
// pop on empty, push on full and unknown codes; a checker compares results.
// ----------------------------------------------------------------------------
module queue_with_middle_insert_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                        DEPTH       = qmi_pkg::QUEUE_DEPTH_DEF;
	localparam logic [qmi_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;
	localparam int                        CYCLE_LIMIT = 200000;
	localparam int                        DRAIN_LIMIT = 200;

	logic                              clk      = 1'b0;
	logic                              arst_n   = 1'b0;
	logic                              start    = 1'b0;
	logic [qmi_pkg::REQ_W-1:0]         req_type = qmi_pkg::REQ_POP;
	logic signed [qmi_pkg::DATA_W-1:0] value    = '0;
	logic                              busy;
	logic                              done;
	logic signed [qmi_pkg::DATA_W-1:0] popped_value;
	logic [qmi_pkg::STATUS_W-1:0]      status;
	int                                mismatches;
	int                                outstanding;
	int                                cycles     = 0;
	int                                level      = 0;
	int                                burst_left = 0;

	queue_with_middle_insert_core #(.QUEUE_DEPTH(DEPTH)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.value        (value),
		.done         (done),
		.popped_value (popped_value),
		.status       (status)
	);

	queue_with_middle_insert_checker #(.QUEUE_DEPTH(DEPTH)) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.value        (value),
		.done         (done),
		.popped_value (popped_value),
		.status       (status),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic signed [qmi_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: pick_value = 32'h7fff_ffff;
			1: pick_value = 32'h8000_0000;
			2: pick_value = '0;
			3: pick_value = '1;
			default: pick_value = $urandom;
		endcase
	endfunction

	function automatic logic [qmi_pkg::REQ_W-1:0] pick_req(input int pop_pct,
			input int unk_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < unk_pct)
			pick_req = REQ_UNKNOWN;
		else if (r < unk_pct + pop_pct)
			pick_req = qmi_pkg::REQ_POP;
		else
			pick_req = $urandom_range(0, 1) ? qmi_pkg::REQ_PUSH_MIDDLE
				: qmi_pkg::REQ_PUSH_BACK;
	endfunction

	// One transaction; bursts of random length separated by random gaps.
	task automatic send_req(input logic [qmi_pkg::REQ_W-1:0] kind,
			input logic signed [qmi_pkg::DATA_W-1:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
				req_type <= qmi_pkg::REQ_W'($urandom);
				value <= $urandom;
			end
		end
		@(negedge clk);
		start <= 1'b1;
		req_type <= kind;
		value <= data;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		burst_left--;
		// occupancy is only used to steer the stimulus
		case (kind)
			qmi_pkg::REQ_POP: if (level > 0) level--;
			qmi_pkg::REQ_PUSH_BACK, qmi_pkg::REQ_PUSH_MIDDLE: if (level < DEPTH) level++;
			default: ;
		endcase
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		int waited;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty pop, both pushes into empty, push-middle into a single entry, extremes
		send_req(qmi_pkg::REQ_POP, 32'h1234_5678);
		send_req(qmi_pkg::REQ_PUSH_MIDDLE, 32'h7fff_ffff);
		send_req(qmi_pkg::REQ_PUSH_MIDDLE, 32'h8000_0000);
		send_req(qmi_pkg::REQ_PUSH_BACK, 32'hffff_ffff);
		send_req(qmi_pkg::REQ_PUSH_MIDDLE, 32'h0000_0000);
		send_req(qmi_pkg::REQ_PUSH_BACK, 32'h5555_5555);
		send_req(qmi_pkg::REQ_PUSH_MIDDLE, 32'haaaa_aaaa);
		send_req(REQ_UNKNOWN, 32'h1234_5678);
		repeat (7)
			send_req(qmi_pkg::REQ_POP, 32'hffff_ffff);
		send_req(qmi_pkg::REQ_PUSH_BACK, 32'h0000_0001);
		send_req(REQ_UNKNOWN, 32'hdead_beef);
		send_req(qmi_pkg::REQ_POP, 32'h0);
		send_req(qmi_pkg::REQ_PUSH_BACK, 32'h8000_0000);
		send_req(qmi_pkg::REQ_PUSH_MIDDLE, 32'h7fff_ffff);
		send_req(qmi_pkg::REQ_PUSH_MIDDLE, 32'h0000_0000);
		pause_until_drained();

		// balanced mix around a short queue
		repeat (300)
			send_req(pick_req(40, 5), pick_value());

		// fill to the top, then hover at full so pushes get dropped
		while (level < DEPTH)
			send_req(pick_req(5, 1), pick_value());
		pause_until_drained();
		repeat (80)
			send_req(pick_req(35, 2), pick_value());

		// drain a long stretch of a deep queue
		repeat (300)
			send_req(pick_req(85, 2), pick_value());

		@(negedge clk);
		start <= 1'b0;
		waited = 0;
		while (outstanding != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (outstanding != 0)
			$error("%0d expected results never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### queue_with_middle_insert_core.f
hw/rtl/qmi_pkg.sv
hw/rtl/qmi_cell.sv
hw/rtl/queue_with_middle_insert_core.sv
verif/queue_with_middle_insert_checker.sv
verif/queue_with_middle_insert_core_tb.sv
